// ----- sv/psl_pkg.sv -----
// Shared types and constants of the parenthesized string literal decoder.
package psl_pkg;

   localparam int DEPTH_BITS_DEFAULT = 8;

   // Result queue: a power of two, room for at least two results.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [7:0] BYTE_MASK    = 8'hFF;
   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;
   localparam logic [7:0] CHAR_BSLASH  = 8'h5C;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_BS      = 8'h08;
   localparam logic [7:0] CHAR_FF      = 8'h0C;
   localparam logic [7:0] CHAR_N       = 8'h6E;
   localparam logic [7:0] CHAR_R       = 8'h72;
   localparam logic [7:0] CHAR_T       = 8'h74;
   localparam logic [7:0] CHAR_B       = 8'h62;
   localparam logic [7:0] CHAR_F       = 8'h66;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_SEVEN   = 8'h37;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] result_kind;
      logic       last;
   } result_type;

   // Everything one input byte produces: zero, one or two results.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } dec_out_type;

endpackage

// ----- sv/psl_decode.sv -----
// Escape, newline and nesting decoder holding the scan state.
module psl_decode #(
   parameter int DEPTH_BITS = psl_pkg::DEPTH_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           in_byte,
   input  logic                 source_ended,
   output psl_pkg::dec_out_type dec_out
);

   typedef enum logic [2:0] {
      MODE_PLAIN,
      MODE_CR,
      MODE_ESC,
      MODE_ESC_CR,
      MODE_OCT1,
      MODE_OCT2
   } mode_type;

   typedef struct packed {
      mode_type              mode;
      logic                  emit;
      psl_pkg::result_type   res;
      logic [DEPTH_BITS-1:0] depth;
      logic                  fin;
   } plain_type;

   localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);
   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

   mode_type              mode_ff, mode_in;
   logic [5:0]            oct_ff, oct_in;
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   logic                  fin_ff, fin_in;

   plain_type           plain;
   psl_pkg::result_type pre;
   logic                pre_valid;
   logic                use_plain;
   logic                is_octal;
   logic [DEPTH_BITS-1:0] depth_dec;

   // A byte decoded as plain text, given the current depth.
   always_comb begin
      plain.mode  = MODE_PLAIN;
      plain.emit  = 1'b1;
      plain.res   = '{out_byte: in_byte, result_kind: psl_pkg::KIND_DATA, last: 1'b0};
      plain.depth = depth_ff;
      plain.fin   = fin_ff;
      depth_dec   = (depth_ff != '0) ? depth_ff - DEPTH_ONE : depth_ff;
      case (in_byte)
         psl_pkg::CHAR_LPAREN: begin
            if (depth_ff == DEPTH_MAX) begin
               plain.res.out_byte    = 8'h00;
               plain.res.result_kind = psl_pkg::KIND_ERROR;
            end else begin
               plain.depth = depth_ff + DEPTH_ONE;
            end
         end
         psl_pkg::CHAR_RPAREN: begin
            plain.depth = depth_dec;
            if (depth_dec == '0) begin
               plain.fin             = 1'b1;
               plain.res.out_byte    = 8'h00;
               plain.res.result_kind = psl_pkg::KIND_END;
            end
         end
         psl_pkg::CHAR_CR: begin
            plain.mode = MODE_CR;
            plain.emit = 1'b0;
         end
         psl_pkg::CHAR_BSLASH: begin
            plain.mode = MODE_ESC;
            plain.emit = 1'b0;
         end
         default: begin
         end
      endcase
   end

   assign is_octal = in_byte inside {[psl_pkg::CHAR_ZERO : psl_pkg::CHAR_SEVEN]};

   always_comb begin
      mode_in   = mode_ff;
      oct_in    = oct_ff;
      depth_in  = depth_ff;
      fin_in    = fin_ff;
      pre       = '{out_byte: 8'h00, result_kind: psl_pkg::KIND_DATA, last: 1'b0};
      pre_valid = 1'b0;
      use_plain = 1'b0;

      if (fin_ff) begin
         pre.result_kind = psl_pkg::KIND_END;
         pre_valid       = 1'b1;
      end else if (source_ended) begin
         // Any pending sequence is dropped; the depth is kept.
         mode_in         = MODE_PLAIN;
         oct_in          = '0;
         pre.result_kind = psl_pkg::KIND_ERROR;
         pre_valid       = 1'b1;
      end else begin
         case (mode_ff)
            MODE_CR: begin
               pre.out_byte = psl_pkg::CHAR_LF;
               pre_valid    = 1'b1;
               if (in_byte == psl_pkg::CHAR_LF) begin
                  mode_in = MODE_PLAIN;
               end else begin
                  use_plain = 1'b1;
               end
            end
            MODE_ESC: begin
               mode_in   = MODE_PLAIN;
               pre_valid = 1'b1;
               case (in_byte)
                  psl_pkg::CHAR_N: pre.out_byte = psl_pkg::CHAR_LF;
                  psl_pkg::CHAR_R: pre.out_byte = psl_pkg::CHAR_CR;
                  psl_pkg::CHAR_T: pre.out_byte = psl_pkg::CHAR_TAB;
                  psl_pkg::CHAR_B: pre.out_byte = psl_pkg::CHAR_BS;
                  psl_pkg::CHAR_F: pre.out_byte = psl_pkg::CHAR_FF;
                  psl_pkg::CHAR_LF: pre_valid = 1'b0;
                  psl_pkg::CHAR_CR: begin
                     pre_valid = 1'b0;
                     mode_in   = MODE_ESC_CR;
                  end
                  default: begin
                     if (is_octal) begin
                        pre_valid = 1'b0;
                        oct_in    = {3'b000, in_byte[2:0]};
                        mode_in   = MODE_OCT1;
                     end else begin
                        pre.out_byte = in_byte;
                     end
                  end
               endcase
            end
            MODE_ESC_CR: begin
               if (in_byte == psl_pkg::CHAR_LF) begin
                  mode_in = MODE_PLAIN;
               end else begin
                  use_plain = 1'b1;
               end
            end
            MODE_OCT1: begin
               if (is_octal) begin
                  oct_in  = {oct_ff[2:0], in_byte[2:0]};
                  mode_in = MODE_OCT2;
               end else begin
                  pre.out_byte = {2'b00, oct_ff};
                  pre_valid    = 1'b1;
                  oct_in       = '0;
                  use_plain    = 1'b1;
               end
            end
            MODE_OCT2: begin
               pre_valid = 1'b1;
               oct_in    = '0;
               if (is_octal) begin
                  // The third digit overflows into bit 8, which the slice drops.
                  pre.out_byte = {oct_ff[4:0], in_byte[2:0]} & psl_pkg::BYTE_MASK;
                  mode_in      = MODE_PLAIN;
               end else begin
                  pre.out_byte = {2'b00, oct_ff};
                  use_plain    = 1'b1;
               end
            end
            default: begin
               use_plain = 1'b1;
            end
         endcase
         if (use_plain) begin
            mode_in  = plain.mode;
            depth_in = plain.depth;
            fin_in   = plain.fin;
         end
      end
   end

   // Pack the results in order and mark the final one.
   always_comb begin
      dec_out = '0;
      if (pre_valid) begin
         dec_out.first = pre;
         if (use_plain && plain.emit) begin
            dec_out.count       = 2'd2;
            dec_out.second      = plain.res;
            dec_out.second.last = 1'b1;
         end else begin
            dec_out.count      = 2'd1;
            dec_out.first.last = 1'b1;
         end
      end else if (use_plain && plain.emit) begin
         dec_out.count      = 2'd1;
         dec_out.first      = plain.res;
         dec_out.first.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_PLAIN;
         oct_ff   <= '0;
         depth_ff <= DEPTH_ONE;
         fin_ff   <= 1'b0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         oct_ff   <= oct_in;
         depth_ff <= depth_in;
         fin_ff   <= fin_in;
      end
   end

endmodule

// ----- sv/psl_rsp_queue.sv -----
// Small result queue that takes up to two results a cycle and gives one.
module psl_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  psl_pkg::dec_out_type push_data,
   input  logic                 pop,
   output psl_pkg::result_type  head,
   output logic                 head_valid,
   output logic                 room_for_two
);

   psl_pkg::result_type                 entries_ff [psl_pkg::QUEUE_DEPTH];
   logic [psl_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [psl_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [psl_pkg::QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic [psl_pkg::QUEUE_PTR_BITS-1:0] wr_next;
   logic [1:0]                          push_n;

   assign push_n       = push ? push_data.count : 2'd0;
   assign wr_next      = wr_ptr_ff + psl_pkg::QUEUE_PTR_BITS'(1);
   assign head         = entries_ff[rd_ptr_ff];
   assign head_valid   = (count_ff != '0);
   assign room_for_two = (count_ff <= psl_pkg::QUEUE_CNT_BITS'(psl_pkg::QUEUE_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + psl_pkg::QUEUE_PTR_BITS'(push_n);
      rd_ptr_in = rd_ptr_ff + psl_pkg::QUEUE_PTR_BITS'(pop);
      count_in  = count_ff + psl_pkg::QUEUE_CNT_BITS'(push_n)
                  - psl_pkg::QUEUE_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push_data.first;
      end
      if (push_n == 2'd2) begin
         entries_ff[wr_next] <= push_data.second;
      end
   end

endmodule

// ----- sv/paren_string_literal_decoder_top.sv -----
// Top level of the parenthesized string literal decoder.
// Takes the body of a "( ... )" string literal one raw byte per beat and gives the decoded
// bytes, an end result at the closing paren (and for every byte after it), or an error when
// the source ends or the nesting depth would overflow. Each input beat yields zero, one or two
// result beats, the last flagged with rsp_last. The scan state is updated in the cycle a byte
// is accepted and its results enter a four-entry result queue, so they are offered from the
// next cycle on. A byte is accepted in every cycle while the queue has room for two results;
// the result port drains one beat per cycle while rsp_ready is high, so a run of bytes that
// each give two results stalls the input, and all other traffic is taken at one byte per cycle.
module paren_string_literal_decoder_top #(
   parameter int DEPTH_BITS = psl_pkg::DEPTH_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_source_ended,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_result_kind,
   output logic       rsp_last
);

   psl_pkg::dec_out_type dec_out;
   psl_pkg::result_type  head;
   logic                 accept;
   logic                 room_for_two;

   assign req_ready = room_for_two;
   assign accept    = req_valid && req_ready;

   psl_decode #(
      .DEPTH_BITS(DEPTH_BITS)
   ) u_decode (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_in_byte),
      .source_ended(req_source_ended),
      .dec_out     (dec_out)
   );

   psl_rsp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (accept),
      .push_data   (dec_out),
      .pop         (rsp_valid && rsp_ready),
      .head        (head),
      .head_valid  (rsp_valid),
      .room_for_two(room_for_two)
   );

   assign rsp_out_byte    = head.out_byte;
   assign rsp_result_kind = head.result_kind;
   assign rsp_last        = head.last;

   // Only a byte swallowed into a pending sequence gives no result.
   a_silent_only_on_data: assert property (@(posedge clock) disable iff (reset)
      (accept && dec_out.count == 2'd0) |-> !req_source_ended)
      else $error("byte with source ended gave no result");

   // Of two results, the first is always a data byte and never the last.
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (accept && dec_out.count == 2'd2)
         |-> (dec_out.first.result_kind == psl_pkg::KIND_DATA && !dec_out.first.last))
      else $error("bad first result of a pair");

   // End and error results carry a zero byte.
   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind != psl_pkg::KIND_DATA) |-> rsp_out_byte == 8'h00)
      else $error("non-data result with a nonzero byte");

   // Input is held off only while results are waiting.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with an empty result queue");

endmodule

// ----- tb/paren_string_literal_decoder_top_tb.sv -----
// Self-checking testbench for the parenthesized string literal decoder top level.
module paren_string_literal_decoder_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH_BITS = psl_pkg::DEPTH_BITS_DEFAULT;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [7:0] FILLER_BYTE = 8'h61;
   localparam logic [7:0] CHAR_Q = 8'h71;
   localparam logic [7:0] CHAR_X = 8'h78;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;

   typedef enum logic [2:0] {
      SCAN_PLAIN,
      SCAN_CR,
      SCAN_ESC,
      SCAN_ESC_CR,
      SCAN_OCT1,
      SCAN_OCT2
   } scan_mode_type;

   typedef struct packed {
      scan_mode_type         mode;
      logic [5:0]            octal;
      logic [DEPTH_BITS-1:0] depth;
      logic                  finished;
   } decoder_state_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_source_ended = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_result_kind;
   logic       rsp_last;

   decoder_state_type   decoder_state = '{mode: SCAN_PLAIN, octal: '0,
                                          depth: DEPTH_BITS'(1), finished: 1'b0};
   psl_pkg::result_type expected_results[$];
   int                  failures = 0;
   int                  beats_sent = 0;
   int                  data_seen = 0;
   int                  end_seen = 0;
   int                  error_seen = 0;
   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;
   int                  stall_cycles = 0;

   paren_string_literal_decoder_top #(
      .DEPTH_BITS(DEPTH_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_in_byte(req_in_byte),
      .req_source_ended(req_source_ended),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_result_kind(rsp_result_kind),
      .rsp_last(rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void add_result(inout psl_pkg::result_type [1:0] res, inout int n,
                                      input logic [7:0] b, input logic [1:0] kind);
      res[n].out_byte = b;
      res[n].result_kind = kind;
      res[n].last = 1'b0;
      n++;
   endfunction

   function automatic void decode_plain(inout decoder_state_type s, input logic [7:0] b,
                                        inout psl_pkg::result_type [1:0] res, inout int n);
      s.mode = SCAN_PLAIN;
      if (b == psl_pkg::CHAR_LPAREN) begin
         if (s.depth == '1) begin
            add_result(res, n, 8'h00, psl_pkg::KIND_ERROR);
         end else begin
            s.depth++;
            add_result(res, n, b, psl_pkg::KIND_DATA);
         end
      end else if (b == psl_pkg::CHAR_RPAREN) begin
         if (s.depth != 0) s.depth--;
         if (s.depth == 0) begin
            s.finished = 1'b1;
            add_result(res, n, 8'h00, psl_pkg::KIND_END);
         end else begin
            add_result(res, n, b, psl_pkg::KIND_DATA);
         end
      end else if (b == psl_pkg::CHAR_CR) begin
         s.mode = SCAN_CR;
      end else if (b == psl_pkg::CHAR_BSLASH) begin
         s.mode = SCAN_ESC;
      end else begin
         add_result(res, n, b, psl_pkg::KIND_DATA);
      end
   endfunction

   // Works out the results of one source beat and moves the state on.
   function automatic void decode_byte(inout decoder_state_type s, input logic [7:0] b,
                                       input logic ended,
                                       output psl_pkg::result_type [1:0] res,
                                       output int n);
      logic is_oct;
      is_oct = b inside {[psl_pkg::CHAR_ZERO : psl_pkg::CHAR_SEVEN]};
      res = '0;
      n = 0;
      if (s.finished) begin
         add_result(res, n, 8'h00, psl_pkg::KIND_END);
      end else if (ended) begin
         s.mode = SCAN_PLAIN;
         s.octal = '0;
         add_result(res, n, 8'h00, psl_pkg::KIND_ERROR);
      end else begin
         case (s.mode)
            SCAN_CR: begin
               add_result(res, n, psl_pkg::CHAR_LF, psl_pkg::KIND_DATA);
               if (b == psl_pkg::CHAR_LF) s.mode = SCAN_PLAIN;
               else decode_plain(s, b, res, n);
            end
            SCAN_ESC: begin
               s.mode = SCAN_PLAIN;
               case (b)
                  psl_pkg::CHAR_N: add_result(res, n, psl_pkg::CHAR_LF, psl_pkg::KIND_DATA);
                  psl_pkg::CHAR_R: add_result(res, n, psl_pkg::CHAR_CR, psl_pkg::KIND_DATA);
                  psl_pkg::CHAR_T: add_result(res, n, psl_pkg::CHAR_TAB, psl_pkg::KIND_DATA);
                  psl_pkg::CHAR_B: add_result(res, n, psl_pkg::CHAR_BS, psl_pkg::KIND_DATA);
                  psl_pkg::CHAR_F: add_result(res, n, psl_pkg::CHAR_FF, psl_pkg::KIND_DATA);
                  psl_pkg::CHAR_LF: ;
                  psl_pkg::CHAR_CR: s.mode = SCAN_ESC_CR;
                  default: begin
                     if (is_oct) begin
                        s.octal = {3'b000, b[2:0]};
                        s.mode = SCAN_OCT1;
                     end else begin
                        add_result(res, n, b, psl_pkg::KIND_DATA);
                     end
                  end
               endcase
            end
            SCAN_ESC_CR: begin
               if (b == psl_pkg::CHAR_LF) s.mode = SCAN_PLAIN;
               else decode_plain(s, b, res, n);
            end
            SCAN_OCT1, SCAN_OCT2: begin
               if (is_oct && s.mode == SCAN_OCT1) begin
                  s.octal = {s.octal[2:0], b[2:0]};
                  s.mode = SCAN_OCT2;
               end else if (is_oct) begin
                  add_result(res, n, {s.octal[4:0], b[2:0]}, psl_pkg::KIND_DATA);
                  s.octal = '0;
                  s.mode = SCAN_PLAIN;
               end else begin
                  // A short escape gives its value, then the byte that ended it.
                  add_result(res, n, {2'b00, s.octal}, psl_pkg::KIND_DATA);
                  s.octal = '0;
                  decode_plain(s, b, res, n);
               end
            end
            default: decode_plain(s, b, res, n);
         endcase
      end
      if (n > 0) res[n-1].last = 1'b1;
   endfunction

   task automatic report_failure(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      failures++;
   endtask

   task automatic send_beat(input logic [7:0] b, input logic ended);
      psl_pkg::result_type [1:0] res;
      int n;
      @(negedge clock);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_source_ended <= ended;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_byte(decoder_state, b, ended, res, n);
      for (int i = 0; i < n; i++) expected_results.push_back(res[i]);
      beats_sent++;
   endtask

   // Holds the sender off until every expected result beat has arrived.
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      psl_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         case (rsp_result_kind)
            psl_pkg::KIND_DATA: data_seen++;
            psl_pkg::KIND_END:  end_seen++;
            default:            error_seen++;
         endcase
         if (expected_results.size() == 0) begin
            report_failure($sformatf("unexpected result byte=%02h kind=%0d last=%0b",
                                     rsp_out_byte, rsp_result_kind, rsp_last));
         end else begin
            want = expected_results.pop_front();
            if (rsp_out_byte !== want.out_byte || rsp_result_kind !== want.result_kind ||
                rsp_last !== want.last) begin
               report_failure($sformatf("got byte=%02h kind=%0d last=%0b, want %02h/%0d/%0b",
                                        rsp_out_byte, rsp_result_kind, rsp_last,
                                        want.out_byte, want.result_kind, want.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic test_directed();
      send_idle_pct = 19;
      recv_idle_pct = 80;
      send_beat(psl_pkg::CHAR_LPAREN, 1'b0);
      send_beat(psl_pkg::CHAR_RPAREN, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(psl_pkg::CHAR_BSLASH, 1'b0); send_beat(psl_pkg::CHAR_N, 1'b0);
      send_beat(psl_pkg::CHAR_BSLASH, 1'b0); send_beat(psl_pkg::CHAR_B, 1'b0);
      send_beat(psl_pkg::CHAR_BSLASH, 1'b0); send_beat(psl_pkg::CHAR_LPAREN, 1'b0);
      send_beat(psl_pkg::CHAR_BSLASH, 1'b0); send_beat(psl_pkg::CHAR_BSLASH, 1'b0);
      // Three sevens overflow eight bits and are masked.
      send_beat(psl_pkg::CHAR_BSLASH, 1'b0); send_beat(psl_pkg::CHAR_SEVEN, 1'b0);
      send_beat(psl_pkg::CHAR_SEVEN, 1'b0); send_beat(psl_pkg::CHAR_SEVEN, 1'b0);
      send_beat(psl_pkg::CHAR_BSLASH, 1'b0); send_beat(8'h35, 1'b0); send_beat(CHAR_X, 1'b0);
      send_beat(psl_pkg::CHAR_CR, 1'b0); send_beat(CHAR_UPPER_A, 1'b0);
      send_beat(psl_pkg::CHAR_CR, 1'b0); send_beat(psl_pkg::CHAR_LF, 1'b0);
      send_beat(psl_pkg::CHAR_BSLASH, 1'b0); send_beat(psl_pkg::CHAR_CR, 1'b0);
      send_beat(CHAR_UPPER_Z, 1'b0);
      send_beat(psl_pkg::CHAR_BSLASH, 1'b0); send_beat(psl_pkg::CHAR_LF, 1'b0);
      send_beat(psl_pkg::CHAR_BSLASH, 1'b0); send_beat(CHAR_Q, 1'b0);
      send_beat(psl_pkg::CHAR_BSLASH, 1'b0); send_beat(8'hA5, 1'b1);
   endtask

   // Mostly well-formed text with random content; a byte that would close the
   // string is swapped for a plain letter so that decoding carries on.
   task automatic test_random(input int count, input int s_idle, input int r_idle);
      decoder_state_type trial;
      psl_pkg::result_type [1:0] res;
      int n;
      int pick;
      logic [7:0] b;
      logic ended;
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         ended = 1'b0;
         if (pick < 3) begin
            b = 8'($urandom_range(255));
            ended = 1'b1;
         end else if (pick < 33) b = 8'($urandom_range(8'h20, 8'h7E));
         else if (pick < 43) b = psl_pkg::CHAR_LPAREN;
         else if (pick < 53) b = psl_pkg::CHAR_RPAREN;
         else if (pick < 58) b = psl_pkg::CHAR_CR;
         else if (pick < 63) b = psl_pkg::CHAR_LF;
         else if (pick < 76) b = psl_pkg::CHAR_BSLASH;
         else if (pick < 84) begin
            case ($urandom_range(4))
               0:       b = psl_pkg::CHAR_N;
               1:       b = psl_pkg::CHAR_R;
               2:       b = psl_pkg::CHAR_T;
               3:       b = psl_pkg::CHAR_B;
               default: b = psl_pkg::CHAR_F;
            endcase
         end else if (pick < 92) b = psl_pkg::CHAR_ZERO + 8'($urandom_range(7));
         else b = 8'($urandom_range(255));
         trial = decoder_state;
         decode_byte(trial, b, ended, res, n);
         if (trial.finished) b = FILLER_BYTE;
         send_beat(b, ended);
      end
   endtask

   task automatic test_depth_overflow();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (decoder_state.depth != '1) send_beat(psl_pkg::CHAR_LPAREN, 1'b0);
      send_beat(psl_pkg::CHAR_LPAREN, 1'b0);
      send_beat(psl_pkg::CHAR_CR, 1'b0); send_beat(psl_pkg::CHAR_LPAREN, 1'b0);
      send_beat(psl_pkg::CHAR_BSLASH, 1'b0); send_beat(psl_pkg::CHAR_LPAREN, 1'b0);
      send_beat(FILLER_BYTE, 1'b0);
      while (decoder_state.depth > 1) send_beat(psl_pkg::CHAR_RPAREN, 1'b0);
   endtask

   task automatic test_end_of_string();
      while (!decoder_state.finished) send_beat(psl_pkg::CHAR_RPAREN, 1'b0);
      send_beat(psl_pkg::CHAR_LPAREN, 1'b0);
      send_beat(psl_pkg::CHAR_BSLASH, 1'b0);
      repeat (6) send_beat(8'($urandom_range(255)), 1'($urandom_range(1)));
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(130, 19, 80);
      test_random(130, 80, 19);
      test_random(130, 0, 0);
      wait_for_results();
      test_depth_overflow();
      test_random(20, 0, 0);
      test_end_of_string();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("summary: %0d source beats, %0d data, %0d end and %0d error result beats",
               beats_sent, data_seen, end_seen, error_seen);
      $display("covered: escapes, octal, line endings, nesting to saturation, source end");
      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/psl_pkg.sv
sv/psl_decode.sv
sv/psl_rsp_queue.sv
sv/paren_string_literal_decoder_top.sv
tb/paren_string_literal_decoder_top_tb.sv
